@@ hw/rtl/clipped_rect_and_line_fill_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle and line fill engine
// Shared forms for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_RECT_AND_LINE_FILL_TOP_DEFINES_SVH
`define CLIPPED_RECT_AND_LINE_FILL_TOP_DEFINES_SVH

// Check that is switched off while reset is high.
`define CLRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define CLRF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/clrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Package for the rectangle and line fill engine
// Operation codes, status codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package clrf_pkg;

  localparam int COORD_W      = 17;
  localparam int CALC_W       = 20;
  localparam int COLOR_W      = 24;
  localparam int STATUS_W     = 2;
  localparam int CANVAS_REG_W = 9;
  localparam int CFG_INDEX_W  = 2;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_LINE = 2'd1,
    OP_READ = 2'd2,
    OP_INIT = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DIAGONAL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_W   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_H   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP,
    ST_DECIDE,
    ST_BASE,
    ST_FILL,
    ST_CLEAR,
    ST_RADDR,
    ST_RDATA,
    ST_DONE
  } state_t;

  // Classification of the current request, from the geometry unit.
  typedef struct packed {
    logic diag;
    logic outside;
    logic empty;
  } geom_flags_t;

endpackage

@@ hw/rtl/clipped_rect_and_line_fill_top.sv @@
// ----------------------------------------------------------------------------
// Rectangle and line fill engine, top level
// Framebuffer engine that fills clipped rectangles and axis-aligned lines,
// reads single pixels and initialises the store with a background colour.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_stall with op and its operands; each one
//   gives exactly one result on out_valid/out_stall (pixel_color, status).
//   The block takes one request at a time: in_stall stays high from the
//   cycle after acceptance until the result has entered the output register.
//   A fill or line writes its clipped area, and an init the whole store,
//   pixel by pixel through the single write port of the frame store; an
//   empty or diagonal request writes nothing, and a read outside the canvas
//   does not touch the store.
//   The output register holds a result while out_stall is high; the next
//   request can already be worked on meanwhile and waits only at its end.
//   Configuration writes (cfg_valid/cfg_ready, always ready) must be made
//   only while the block is idle, which the block does not enforce. Reset
//   clears the control state and sets the canvas to 256 x 256 with a black
//   background; the store is undefined until an init or a fill writes it.
// ----------------------------------------------------------------------------
module clipped_rect_and_line_fill_top
  import clrf_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                op,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] extent_w,
  input  logic signed [COORD_W-1:0] extent_h,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic signed [COORD_W-1:0] thickness,
  input  logic [COLOR_W-1:0]        color,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COLOR_W-1:0]        pixel_color,
  output logic [STATUS_W-1:0]       status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [COLOR_W-1:0]        cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW     = $clog2(MAX_WIDTH + 1);
  localparam int YW     = $clog2(MAX_HEIGHT + 1);

  logic [CANVAS_REG_W-1:0] canvas_width, canvas_height;
  logic [COLOR_W-1:0]      background_color;
  logic [COLOR_W-1:0]      color_q;
  logic [XW-1:0]           act_w;
  logic [YW-1:0]           act_h;
  logic [XW-1:0]           left, right;
  logic [YW-1:0]           top, bottom;
  geom_flags_t             flags;
  logic                    in_accept, idle, load_clip, slot_free;
  logic                    mem_we, mem_re, fill_bg, res_valid;
  logic [ADDR_W-1:0]       mem_addr;
  logic [COLOR_W-1:0]      mem_rdata, mem_wdata, res_pixel;
  logic [STATUS_W-1:0]     res_status;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = !idle;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width     <= CANVAS_REG_W'(256);
      canvas_height    <= CANVAS_REG_W'(256);
      background_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CANVAS_W:   canvas_width     <= cfg_data[CANVAS_REG_W-1:0];
        REG_CANVAS_H:   canvas_height    <= cfg_data[CANVAS_REG_W-1:0];
        REG_BACKGROUND: background_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Active canvas size, at least one pixel and at most the store size.
  always_comb begin
    if (canvas_width == '0) begin
      act_w = XW'(1);
    end else if (int'(canvas_width) > MAX_WIDTH) begin
      act_w = XW'(MAX_WIDTH);
    end else begin
      act_w = XW'(canvas_width);
    end
    if (canvas_height == '0) begin
      act_h = YW'(1);
    end else if (int'(canvas_height) > MAX_HEIGHT) begin
      act_h = YW'(MAX_HEIGHT);
    end else begin
      act_h = YW'(canvas_height);
    end
  end

  // Colour of the accepted request.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      color_q <= color;
    end
  end

  assign mem_wdata = fill_bg ? background_color : color_q;

  clrf_geom #(
    .XW (XW),
    .YW (YW)
  ) u_geom (
    .clk       (clk),
    .load_raw  (in_accept),
    .load_clip (load_clip),
    .op        (op),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .extent_w  (extent_w),
    .extent_h  (extent_h),
    .end_x     (end_x),
    .end_y     (end_y),
    .thickness (thickness),
    .act_w     (act_w),
    .act_h     (act_h),
    .left      (left),
    .right     (right),
    .top       (top),
    .bottom    (bottom),
    .flags     (flags)
  );

  clrf_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .XW        (XW),
    .YW        (YW),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .op         (op),
    .left       (left),
    .right      (right),
    .top        (top),
    .bottom     (bottom),
    .flags      (flags),
    .slot_free  (slot_free),
    .mem_rdata  (mem_rdata),
    .idle       (idle),
    .load_clip  (load_clip),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .fill_bg    (fill_bg),
    .mem_addr   (mem_addr),
    .res_valid  (res_valid),
    .res_pixel  (res_pixel),
    .res_status (res_status)
  );

  clrf_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      pixel_color <= res_pixel;
      status      <= res_status;
    end
  end

endmodule

@@ hw/rtl/clrf_geom.sv @@
// ----------------------------------------------------------------------------
// Geometry unit
// Turns a fill or line request into a rectangle and clips it to the canvas,
// in two registered steps.
// ----------------------------------------------------------------------------
module clrf_geom
  import clrf_pkg::*;
#(
  parameter int XW = 9,
  parameter int YW = 9
) (
  input  logic                      clk,
  input  logic                      load_raw,
  input  logic                      load_clip,
  input  logic [1:0]                op,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] extent_w,
  input  logic signed [COORD_W-1:0] extent_h,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic signed [COORD_W-1:0] thickness,
  input  logic [XW-1:0]             act_w,
  input  logic [YW-1:0]             act_h,
  output logic [XW-1:0]             left,
  output logic [XW-1:0]             right,
  output logic [YW-1:0]             top,
  output logic [YW-1:0]             bottom,
  output geom_flags_t               flags
);

  localparam int PAD = CALC_W - COORD_W;

  logic signed [CALC_W-1:0] px_e, py_e, ew_e, eh_e, ex_e, ey_e, th_e;
  logic signed [CALC_W-1:0] th_adj, half;
  logic signed [CALC_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [CALC_W-1:0] raw_l_c, raw_r_c, raw_t_c, raw_b_c;
  logic                     diag_c;
  logic signed [CALC_W-1:0] raw_l, raw_r, raw_t, raw_b;
  logic                     raw_diag;
  logic signed [CALC_W-1:0] w_ext, h_ext;
  logic [XW-1:0]            cl_l, cl_r;
  logic [YW-1:0]            cl_t, cl_b;
  logic                     outside_c;

  function automatic logic [XW-1:0] clamp_x(input logic signed [CALC_W-1:0] v,
                                            input logic signed [CALC_W-1:0] hi);
    logic [XW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi[XW-1:0];
    end else begin
      r = v[XW-1:0];
    end
    return r;
  endfunction

  function automatic logic [YW-1:0] clamp_y(input logic signed [CALC_W-1:0] v,
                                            input logic signed [CALC_W-1:0] hi);
    logic [YW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi[YW-1:0];
    end else begin
      r = v[YW-1:0];
    end
    return r;
  endfunction

  // Sign-extend the coordinates to the working width.
  assign px_e = {{PAD{pos_x[COORD_W-1]}}, pos_x};
  assign py_e = {{PAD{pos_y[COORD_W-1]}}, pos_y};
  assign ew_e = {{PAD{extent_w[COORD_W-1]}}, extent_w};
  assign eh_e = {{PAD{extent_h[COORD_W-1]}}, extent_h};
  assign ex_e = {{PAD{end_x[COORD_W-1]}}, end_x};
  assign ey_e = {{PAD{end_y[COORD_W-1]}}, end_y};
  assign th_e = {{PAD{thickness[COORD_W-1]}}, thickness};

  // Half thickness, rounded toward zero.
  assign th_adj = th_e + {{(CALC_W-1){1'b0}}, th_e[CALC_W-1]};
  assign half   = th_adj >>> 1;

  assign min_x = (px_e < ex_e) ? px_e : ex_e;
  assign max_x = (px_e < ex_e) ? ex_e : px_e;
  assign min_y = (py_e < ey_e) ? py_e : ey_e;
  assign max_y = (py_e < ey_e) ? ey_e : py_e;

  // Unclipped rectangle edges; right and bottom are exclusive.
  always_comb begin
    raw_l_c = px_e;
    raw_r_c = px_e + ew_e;
    raw_t_c = py_e;
    raw_b_c = py_e + eh_e;
    diag_c  = 1'b0;
    if (op_t'(op) == OP_LINE) begin
      if (px_e == ex_e) begin
        raw_l_c = px_e - half;
        raw_r_c = px_e - half + th_e;
        raw_t_c = min_y;
        raw_b_c = max_y + {{(CALC_W-1){1'b0}}, 1'b1};
      end else if (py_e == ey_e) begin
        raw_l_c = min_x;
        raw_r_c = max_x + {{(CALC_W-1){1'b0}}, 1'b1};
        raw_t_c = py_e - half;
        raw_b_c = py_e - half + th_e;
      end else begin
        diag_c  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_raw) begin
      raw_l    <= raw_l_c;
      raw_r    <= raw_r_c;
      raw_t    <= raw_t_c;
      raw_b    <= raw_b_c;
      raw_diag <= diag_c;
    end
  end

  // Clip to the active canvas.
  assign w_ext = {{(CALC_W-XW){1'b0}}, act_w};
  assign h_ext = {{(CALC_W-YW){1'b0}}, act_h};
  assign cl_l  = clamp_x(raw_l, w_ext);
  assign cl_r  = clamp_x(raw_r, w_ext);
  assign cl_t  = clamp_y(raw_t, h_ext);
  assign cl_b  = clamp_y(raw_b, h_ext);

  // A read uses the unclipped start point.
  assign outside_c = (raw_l < 0) || (raw_l >= w_ext) || (raw_t < 0) || (raw_t >= h_ext);

  always_ff @(posedge clk) begin
    if (load_clip) begin
      left          <= cl_l;
      right         <= cl_r;
      top           <= cl_t;
      bottom        <= cl_b;
      flags.diag    <= raw_diag;
      flags.outside <= outside_c;
      flags.empty   <= (cl_r <= cl_l) || (cl_b <= cl_t);
    end
  end

endmodule

@@ hw/rtl/clrf_mem.sv @@
// ----------------------------------------------------------------------------
// Frame store
// Single-port pixel memory with a registered read.
// ----------------------------------------------------------------------------
module clrf_mem
  import clrf_pkg::*;
#(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [COLOR_W-1:0] wdata,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] store [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      store[addr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[addr];
    end
  end

endmodule

@@ hw/rtl/clrf_seq.sv @@
// ----------------------------------------------------------------------------
// Sequencer and raster walker
// Steps one request through clipping, then walks the clipped area (or the
// whole store for an init) one pixel per cycle, or performs a single read.
// ----------------------------------------------------------------------------
module clrf_seq
  import clrf_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int XW        = 9,
  parameter int YW        = 9,
  parameter int DEPTH     = 65536,
  parameter int ADDR_W    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_accept,
  input  logic [1:0]          op,
  input  logic [XW-1:0]       left,
  input  logic [XW-1:0]       right,
  input  logic [YW-1:0]       top,
  input  logic [YW-1:0]       bottom,
  input  geom_flags_t         flags,
  input  logic                slot_free,
  input  logic [COLOR_W-1:0]  mem_rdata,
  output logic                idle,
  output logic                load_clip,
  output logic                mem_we,
  output logic                mem_re,
  output logic                fill_bg,
  output logic [ADDR_W-1:0]   mem_addr,
  output logic                res_valid,
  output logic [COLOR_W-1:0]  res_pixel,
  output logic [STATUS_W-1:0] res_status
);

  state_t              state, state_next;
  op_t                 op_q;
  logic [XW-1:0]       x;
  logic [YW-1:0]       y;
  logic [ADDR_W-1:0]   row_base;
  logic [ADDR_W-1:0]   clr_addr;
  logic                x_last, y_last, clr_last;

  assign x_last   = (x + 1'b1) == right;
  assign y_last   = (y + 1'b1) == bottom;
  assign clr_last = clr_addr == ADDR_W'(DEPTH - 1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept) state_next = ST_CLIP;
      ST_CLIP:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        case (op_q)
          OP_INIT: state_next = ST_CLEAR;
          OP_READ: state_next = flags.outside ? ST_DONE : ST_BASE;
          OP_LINE: state_next = (flags.diag || flags.empty) ? ST_DONE : ST_BASE;
          default: state_next = flags.empty ? ST_DONE : ST_BASE;
        endcase
      end
      ST_BASE:   state_next = (op_q == OP_READ) ? ST_RADDR : ST_FILL;
      ST_FILL:   if (x_last && y_last) state_next = ST_DONE;
      ST_CLEAR:  if (clr_last) state_next = ST_DONE;
      ST_RADDR:  state_next = ST_RDATA;
      ST_RDATA:  state_next = ST_DONE;
      ST_DONE:   if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    idle      = (state == ST_IDLE);
    load_clip = (state == ST_CLIP);
    mem_we    = (state == ST_FILL) || (state == ST_CLEAR);
    mem_re    = (state == ST_RADDR);
    fill_bg   = (state == ST_CLEAR);
    mem_addr  = (state == ST_CLEAR) ? clr_addr : row_base + ADDR_W'(x);
    res_valid = (state == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walker counters and the result being built.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          op_q <= op_t'(op);
        end
      end
      ST_DECIDE: begin
        x         <= left;
        y         <= top;
        clr_addr  <= '0;
        res_pixel <= '0;
        if (op_q == OP_READ && flags.outside) begin
          res_status <= STATUS_OUTSIDE;
        end else if (op_q == OP_LINE && flags.diag) begin
          res_status <= STATUS_DIAGONAL;
        end else begin
          res_status <= STATUS_OK;
        end
      end
      ST_BASE: begin
        row_base <= ADDR_W'(int'(y) * MAX_WIDTH);
      end
      ST_FILL: begin
        if (x_last) begin
          x        <= left;
          y        <= y + 1'b1;
          row_base <= row_base + ADDR_W'(MAX_WIDTH);
        end else begin
          x <= x + 1'b1;
        end
      end
      ST_CLEAR: begin
        clr_addr <= clr_addr + 1'b1;
      end
      ST_RDATA: begin
        res_pixel <= mem_rdata;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/clrf_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker for the rectangle and line fill engine
// Watches the top-level ports and flags behaviour the block must never show.
// ----------------------------------------------------------------------------
`include "clipped_rect_and_line_fill_top_defines.svh"

module clrf_checker
  import clrf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [COLOR_W-1:0]  pixel_color,
  input logic [STATUS_W-1:0] status
);

  // No result may be offered in the cycle after a reset cycle.
  `CLRF_ASSERT_ALWAYS(a_no_result_after_reset, rst |=> !out_valid, "result after reset")

  // A stalled result stays put.
  `CLRF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(pixel_color) && $stable(status), "stalled result changed")

  // Requests are taken one at a time.
  `CLRF_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second request taken while busy")

  // Only a successful read carries a colour.
  `CLRF_ASSERT(a_error_no_colour, out_valid && status != STATUS_OK |-> pixel_color == '0, "colour with error status")

endmodule

bind clipped_rect_and_line_fill_top clrf_checker u_clrf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_color (pixel_color),
  .status      (status)
);
